// File: rtl/mpgp_pkg.sv
// Shared types and constants for the mask pixel ground projection block.
// No dependencies.
package mpgp_pkg;

    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [REG_IDX_W-1:0] REG_FOCAL_X       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_X       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION_QUAT = 3'd7;

    // quotient magnitude bits; results saturate at 2^31-1
    localparam int         QBITS = 31;
    localparam logic [30:0] QSAT = 31'h7FFF_FFFF;

    localparam logic [7:0] GROUND_VALUE = 8'd255;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0]  mask_value;
        logic        end_of_frame;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               point_valid;
        logic               zero_row;
        logic               frame_done;
    } point_t;

    // sideband carried with each transaction down the pipeline
    typedef struct packed {
        logic               ground;
        logic               zero_row;
        logic               eof;
        logic               neg;
        logic signed [13:0] col_off;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_z;
    } tag_t;

endpackage

// File: rtl/mpgp_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^31-1.
// Depends on mpgp_pkg.
module mpgp_div #(
    parameter int NW = 66,
    parameter int DW = 29
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [NW-1:0]           in_num,
    input  logic [DW-1:0]           in_den,
    input  mpgp_pkg::tag_t          in_tag,
    output logic                    out_valid,
    output logic [mpgp_pkg::QBITS-1:0] out_quot,
    output mpgp_pkg::tag_t          out_tag
);

    localparam int QB    = mpgp_pkg::QBITS;
    localparam int HW    = NW - QB;
    localparam int CW    = (HW > DW) ? HW : DW;
    localparam int STEPS = QB;

    logic [STEPS:0] v_reg;
    logic [STEPS:0] sat_reg;
    logic [DW-1:0]  rem_reg [STEPS+1];
    logic [DW-1:0]  den_reg [STEPS+1];
    logic [QB-1:0]  low_reg [STEPS+1];
    logic [QB-1:0]  quo_reg [STEPS+1];
    mpgp_pkg::tag_t tag_reg [STEPS+1];

    logic [CW-1:0]  up_ext;
    logic           sat_next;
    logic [DW:0]    trial [1:STEPS];
    logic [DW:0]    diff  [1:STEPS];
    logic           ge    [1:STEPS];

    always_comb
    begin
        up_ext   = CW'(in_num[NW-1:QB]);
        sat_next = up_ext >= CW'(in_den);
        for (int k = 1; k <= STEPS; k++)
        begin
            trial[k] = {rem_reg[k-1], low_reg[k-1][QB-1]};
            diff[k]  = trial[k] - {1'b0, den_reg[k-1]};
            ge[k]    = trial[k] >= {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= up_ext[DW-1:0];
        den_reg[0] <= in_den;
        low_reg[0] <= in_num[QB-1:0];
        quo_reg[0] <= '0;
        sat_reg[0] <= sat_next;
        tag_reg[0] <= in_tag;
        for (int k = 1; k <= STEPS; k++)
        begin
            rem_reg[k] <= ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
            den_reg[k] <= den_reg[k-1];
            low_reg[k] <= {low_reg[k-1][QB-2:0], 1'b0};
            quo_reg[k] <= {quo_reg[k-1][QB-2:0], ge[k]};
            sat_reg[k] <= sat_reg[k-1];
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_quot  = sat_reg[STEPS] ? mpgp_pkg::QSAT : quo_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];

endmodule

// File: rtl/mpgp_rot.sv
// Quaternion rotation and translation of the camera-frame point, three stages.
// Builds the Q.28 rotation matrix from the quaternion register. Depends on mpgp_pkg.
module mpgp_rot (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  mpgp_pkg::tag_t     in_tag,
    input  logic signed [31:0] in_cam_y,
    input  logic [63:0]        quat,
    input  logic [31:0]        shift_x,
    input  logic [31:0]        shift_y,
    input  logic [31:0]        shift_z,
    output logic               out_valid,
    output mpgp_pkg::point_t   out_point
);

    localparam logic signed [33:0] ONE   = 34'sd268435456;
    localparam logic signed [67:0] ROUND = 68'sd134217728;

    function automatic logic signed [33:0] ext34(logic signed [31:0] a);
        return {{2{a[31]}}, a};
    endfunction

    logic signed [15:0] qx, qy, qz, qw;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] xw_reg, yw_reg, zw_reg;
    logic signed [33:0] mat_reg [3][3];

    logic signed [31:0] cam [3];
    logic signed [65:0] prod_reg [3][3];
    logic signed [67:0] sum_reg  [3];
    logic signed [67:0] sum_next [3];
    logic [31:0]        sh [3];
    logic signed [31:0] res [3];
    logic signed [39:0] qv;
    logic signed [40:0] tot;

    logic          p_valid_reg, s_valid_reg, f_valid_reg;
    mpgp_pkg::tag_t p_tag_reg, s_tag_reg;
    mpgp_pkg::point_t f_point_reg;

    assign qx = quat[15:0];
    assign qy = quat[31:16];
    assign qz = quat[47:32];
    assign qw = quat[63:48];

    always_ff @(posedge clk)
    begin
        xx_reg <= qx * qx;
        yy_reg <= qy * qy;
        zz_reg <= qz * qz;
        xy_reg <= qx * qy;
        xz_reg <= qx * qz;
        yz_reg <= qy * qz;
        xw_reg <= qx * qw;
        yw_reg <= qy * qw;
        zw_reg <= qz * qw;
        mat_reg[0][0] <= ONE - ((ext34(yy_reg) + ext34(zz_reg)) <<< 1);
        mat_reg[0][1] <= (ext34(xy_reg) - ext34(zw_reg)) <<< 1;
        mat_reg[0][2] <= (ext34(xz_reg) + ext34(yw_reg)) <<< 1;
        mat_reg[1][0] <= (ext34(xy_reg) + ext34(zw_reg)) <<< 1;
        mat_reg[1][1] <= ONE - ((ext34(xx_reg) + ext34(zz_reg)) <<< 1);
        mat_reg[1][2] <= (ext34(yz_reg) - ext34(xw_reg)) <<< 1;
        mat_reg[2][0] <= (ext34(xz_reg) - ext34(yw_reg)) <<< 1;
        mat_reg[2][1] <= (ext34(yz_reg) + ext34(xw_reg)) <<< 1;
        mat_reg[2][2] <= ONE - ((ext34(xx_reg) + ext34(yy_reg)) <<< 1);
    end

    always_comb
    begin
        cam[0] = in_tag.cam_x;
        cam[1] = in_cam_y;
        cam[2] = in_tag.cam_z;
        sh[0]  = shift_x;
        sh[1]  = shift_y;
        sh[2]  = shift_z;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = 68'(prod_reg[i][0]) + 68'(prod_reg[i][1])
                        + 68'(prod_reg[i][2]) + ROUND;
        end
    end

    // round to nearest at >>28, add translation, saturate
    always_comb
    begin
        qv  = '0;
        tot = '0;
        for (int i = 0; i < 3; i++)
        begin
            qv  = sum_reg[i][67:28];
            tot = $signed({qv[39], qv}) + $signed({{9{sh[i][31]}}, sh[i]});
            if (tot > 41'sd2147483647)
            begin
                res[i] = 32'sh7FFF_FFFF;
            end
            else if (tot < -41'sd2147483648)
            begin
                res[i] = 32'sh8000_0000;
            end
            else
            begin
                res[i] = tot[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
            f_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[i][j] <= mat_reg[i][j] * cam[j];
            end
            sum_reg[i] <= sum_next[i];
        end
        p_tag_reg <= in_tag;
        s_tag_reg <= p_tag_reg;
        if (s_tag_reg.ground && !s_tag_reg.zero_row)
        begin
            f_point_reg.point_x <= res[0];
            f_point_reg.point_y <= res[1];
            f_point_reg.point_z <= res[2];
        end
        else
        begin
            f_point_reg.point_x <= '0;
            f_point_reg.point_y <= '0;
            f_point_reg.point_z <= '0;
        end
        f_point_reg.point_valid <= s_tag_reg.ground;
        f_point_reg.zero_row    <= s_tag_reg.zero_row;
        f_point_reg.frame_done  <= s_tag_reg.eof;
    end

    assign out_valid = f_valid_reg;
    assign out_point = f_point_reg;

endmodule

// File: rtl/mask_pixel_ground_projection.sv
// Top level of the mask pixel ground projection block: configuration registers,
// front stages, two pipelined dividers and the rotation stage.
// Depends on mpgp_pkg, mpgp_div and mpgp_rot.
//
// Usage:
//   A pixel transaction (cmd) is taken at every rising edge with start high;
//   busy is always low, so one pixel may be issued every clock.
//   A ground pixel (value 255) or a pixel flagged end of frame gives one
//   result; any other pixel gives none. Results appear on result with done
//   high for exactly one cycle, in issue order.
//   Throughput is one pixel per cycle.
//   The pipeline holds the two dividers (32 stages each: an entry stage and
//   31 stages of one quotient bit), the capture, numerator, scaling,
//   signed-depth and signed-lateral stages and three rotation stages.
//   Configuration is written through wr_en / wr_index / wr_data and should
//   only change while no pixel is in flight.
//   Reset clears the pipeline and loads the default camera set-up.
//   The receiver cannot stall; results must be taken when done is high.
module mask_pixel_ground_projection #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mpgp_pkg::pixel_t                    cmd,
    input  logic                                wr_en,
    input  logic [mpgp_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [mpgp_pkg::CFG_DATA_W-1:0]     wr_data,
    output logic                                done,
    output mpgp_pkg::point_t                    result
);

    localparam int          CB    = (COORD_BITS < 12) ? COORD_BITS : 12;
    localparam logic [11:0] CMASK = 12'((64'd1 << CB) - 64'd1);

    logic [15:0] fx_reg, fy_reg;
    logic [12:0] w_reg, h_reg;
    logic [31:0] sx_reg, sy_reg, sz_reg;
    logic [63:0] quat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg   <= 16'd1000;
            fy_reg   <= 16'd1000;
            w_reg    <= 13'd640;
            h_reg    <= 13'd480;
            sx_reg   <= 32'd0;
            sy_reg   <= 32'd0;
            sz_reg   <= 32'd65536;
            quat_reg <= 64'd16384;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mpgp_pkg::REG_FOCAL_X:       fx_reg   <= wr_data[15:0];
                mpgp_pkg::REG_FOCAL_Y:       fy_reg   <= wr_data[15:0];
                mpgp_pkg::REG_IMAGE_WIDTH:   w_reg    <= wr_data[12:0];
                mpgp_pkg::REG_IMAGE_HEIGHT:  h_reg    <= wr_data[12:0];
                mpgp_pkg::REG_SHIFT_X:       sx_reg   <= wr_data[31:0];
                mpgp_pkg::REG_SHIFT_Y:       sy_reg   <= wr_data[31:0];
                mpgp_pkg::REG_SHIFT_Z:       sz_reg   <= wr_data[31:0];
                mpgp_pkg::REG_ROTATION_QUAT: quat_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: capture
    logic        s0_valid_reg, s0_ground_reg, s0_eof_reg;
    logic [11:0] s0_row_reg, s0_col_reg;
    logic        in_ground;

    assign in_ground = cmd.mask_value == mpgp_pkg::GROUND_VALUE;

    // stage 1: numerator, divisor, column offset
    logic [15:0] fy_eff, fx_eff;
    logic [31:0] fy_sq;
    logic [24:0] h_row;
    logic [27:0] fy_row;
    logic [33:0] num_next;
    logic [13:0] col_off_next;

    logic           s1_valid_reg;
    mpgp_pkg::tag_t s1_tag_reg;
    logic [33:0]    s1_num_abs_reg;
    logic [28:0]    s1_den_reg;
    logic [31:0]    s1_tz_abs_reg;

    assign fy_eff       = (fy_reg == '0) ? 16'd1 : fy_reg;
    assign fx_eff       = (fx_reg == '0) ? 16'd1 : fx_reg;
    assign fy_sq        = fy_eff * fy_eff;
    assign h_row        = h_reg * s0_row_reg;
    assign fy_row       = fy_eff * s0_row_reg;
    assign num_next     = {1'b0, fy_sq, 1'b0} - {9'd0, h_row};
    assign col_off_next = {1'b0, s0_col_reg, 1'b0} - {1'b0, w_reg};

    // stage 2: scaled numerator
    logic           s2_valid_reg;
    mpgp_pkg::tag_t s2_tag_reg;
    logic [65:0]    s2_num_reg;
    logic [28:0]    s2_den_reg;

    // divider 1: depth
    logic           d1_valid;
    logic [30:0]    d1_quot;
    mpgp_pkg::tag_t d1_tag;

    // stage 3: signed depth, lateral numerator
    logic [13:0]    co_abs;
    logic [12:0]    co_mag;
    mpgp_pkg::tag_t s3_tag_next;
    logic           s3_valid_reg;
    mpgp_pkg::tag_t s3_tag_reg;
    logic [43:0]    s3_num_reg;
    logic [16:0]    s3_den_reg;

    assign co_abs = d1_tag.col_off[13] ? (14'd0 - d1_tag.col_off) : d1_tag.col_off;
    assign co_mag = co_abs[12:0];

    always_comb
    begin
        s3_tag_next       = d1_tag;
        s3_tag_next.neg   = d1_tag.neg ^ d1_tag.col_off[13];
        s3_tag_next.cam_z = d1_tag.neg ? $signed(32'd0 - {1'b0, d1_quot})
                                       : $signed({1'b0, d1_quot});
    end

    // divider 2: lateral offset
    logic           d2_valid;
    logic [30:0]    d2_quot;
    mpgp_pkg::tag_t d2_tag;

    // stage 4: signed lateral offset
    logic               s4_valid_reg;
    mpgp_pkg::tag_t     s4_tag_reg;
    logic signed [31:0] s4_cam_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy && (in_ground || cmd.end_of_frame);
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= d1_valid;
            s4_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_ground_reg <= in_ground;
        s0_eof_reg    <= cmd.end_of_frame;
        s0_row_reg    <= cmd.row & CMASK;
        s0_col_reg    <= cmd.col & CMASK;

        s1_tag_reg.ground   <= s0_ground_reg;
        s1_tag_reg.zero_row <= s0_ground_reg && (s0_row_reg == '0);
        s1_tag_reg.eof      <= s0_eof_reg;
        s1_tag_reg.neg      <= sz_reg[31] ^ num_next[33];
        s1_tag_reg.col_off  <= col_off_next;
        s1_tag_reg.cam_x    <= (sz_reg == 32'h8000_0000) ? 32'sh7FFF_FFFF
                                                         : $signed(32'd0 - sz_reg);
        s1_tag_reg.cam_z    <= '0;
        s1_num_abs_reg      <= num_next[33] ? (34'd0 - num_next) : num_next;
        s1_den_reg          <= {fy_row, 1'b0};
        s1_tz_abs_reg       <= sz_reg[31] ? (32'd0 - sz_reg) : sz_reg;

        s2_tag_reg <= s1_tag_reg;
        s2_num_reg <= s1_tz_abs_reg * s1_num_abs_reg;
        s2_den_reg <= s1_den_reg;

        s3_tag_reg <= s3_tag_next;
        s3_num_reg <= d1_quot * co_mag;
        s3_den_reg <= {fx_eff, 1'b0};

        s4_tag_reg   <= d2_tag;
        s4_cam_y_reg <= d2_tag.neg ? $signed(32'd0 - {1'b0, d2_quot})
                                   : $signed({1'b0, d2_quot});
    end

    mpgp_div #(
        .NW(66),
        .DW(29)
    ) u_div_depth (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid_reg),
        .in_num   (s2_num_reg),
        .in_den   (s2_den_reg),
        .in_tag   (s2_tag_reg),
        .out_valid(d1_valid),
        .out_quot (d1_quot),
        .out_tag  (d1_tag)
    );

    mpgp_div #(
        .NW(44),
        .DW(17)
    ) u_div_lateral (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s3_valid_reg),
        .in_num   (s3_num_reg),
        .in_den   (s3_den_reg),
        .in_tag   (s3_tag_reg),
        .out_valid(d2_valid),
        .out_quot (d2_quot),
        .out_tag  (d2_tag)
    );

    mpgp_rot u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s4_valid_reg),
        .in_tag   (s4_tag_reg),
        .in_cam_y (s4_cam_y_reg),
        .quat     (quat_reg),
        .shift_x  (sx_reg),
        .shift_y  (sy_reg),
        .shift_z  (sz_reg),
        .out_valid(done),
        .out_point(result)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for mask_pixel_ground_projection: random and directed
// pixel transactions, with a built-in projection predictor compared against each whole result.
// Depends on mpgp_pkg and the mask_pixel_ground_projection RTL.
module tb;

    localparam int LAT_WAIT  = 90;
    localparam int WDOG_MAX  = 3000;
    localparam longint SATP  = 64'sd2147483647;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    mpgp_pkg::pixel_t cmd = '0;
    logic wr_en = 1'b0;
    logic [mpgp_pkg::REG_IDX_W-1:0] wr_index = mpgp_pkg::REG_FOCAL_X;
    logic [mpgp_pkg::CFG_DATA_W-1:0] wr_data = '0;
    logic done;
    mpgp_pkg::point_t result;

    mask_pixel_ground_projection uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .done(done), .result(result)
    );

    always #2 clk = ~clk;

    // camera set-up copy
    logic [15:0] cam_fx = 16'd1000, cam_fy = 16'd1000;
    logic [12:0] img_w = 13'd640, img_h = 13'd480;
    logic signed [31:0] tr_x = 0, tr_y = 0, tr_z = 32'sd65536;
    logic [63:0] quat = 64'd16384;

    mpgp_pkg::pixel_t pixel_q[$];
    mpgp_pkg::point_t point_q[$];
    int gap = 0;
    int mismatches = 0;
    int wdog = 0;

    function automatic void add_pixel(mpgp_pkg::pixel_t p);
        pixel_q.insert(pixel_q.size(), p);
    endfunction

    function automatic longint mul_div_trunc(longint a, longint b, longint d);
        logic [127:0] ua, ub, q;
        ua = 128'(a < 0 ? -a : a);
        ub = 128'(b < 0 ? -b : b);
        q = (ua * ub) / 128'(d);
        if (q > 128'(SATP))
            q = 128'(SATP);
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] rotate_row(longint r0, longint r1, longint r2,
                                                       longint c0, longint c1, longint c2,
                                                       longint sh);
        logic signed [127:0] s;
        longint v;
        s = 128'(r0) * 128'(c0) + 128'(r1) * 128'(c1) + 128'(r2) * 128'(c2);
        s = (s + 128'sd134217728) >>> 28;
        v = longint'(s) + sh;
        if (v > SATP) v = SATP;
        if (v < -SATP - 1) v = -SATP - 1;
        return 32'(v);
    endfunction

    function automatic mpgp_pkg::point_t project_pixel(mpgp_pkg::pixel_t px);
        mpgp_pkg::point_t p;
        longint fx, fy, tz, num, cz, cy, cx, qx, qy, qz, qw;
        longint one;
        p = '0;
        one = 64'sd268435456;
        p.point_valid = (px.mask_value == mpgp_pkg::GROUND_VALUE);
        p.frame_done = px.end_of_frame;
        if (p.point_valid && px.row == 0)
            p.zero_row = 1'b1;
        else if (p.point_valid)
        begin
            fx = (cam_fx == 0) ? 1 : longint'(cam_fx);
            fy = (cam_fy == 0) ? 1 : longint'(cam_fy);
            tz = longint'(tr_z);
            num = 2 * fy * fy - longint'(img_h) * longint'(px.row);
            cz = mul_div_trunc(tz, num, 2 * fy * longint'(px.row));
            cy = mul_div_trunc(cz, 2 * longint'(px.col) - longint'(img_w), 2 * fx);
            cx = (-tz > SATP) ? SATP : -tz;
            qx = longint'($signed(quat[15:0]));
            qy = longint'($signed(quat[31:16]));
            qz = longint'($signed(quat[47:32]));
            qw = longint'($signed(quat[63:48]));
            p.point_x = rotate_row(one - 2 * (qy * qy + qz * qz), 2 * (qx * qy - qz * qw),
                                   2 * (qx * qz + qy * qw), cx, cy, cz, longint'(tr_x));
            p.point_y = rotate_row(2 * (qx * qy + qz * qw), one - 2 * (qx * qx + qz * qz),
                                   2 * (qy * qz - qx * qw), cx, cy, cz, longint'(tr_y));
            p.point_z = rotate_row(2 * (qx * qz - qy * qw), 2 * (qy * qz + qx * qw),
                                   one - 2 * (qx * qx + qy * qy), cx, cy, cz, tz);
        end
        return p;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (cmd.mask_value == mpgp_pkg::GROUND_VALUE || cmd.end_of_frame)
                    point_q.insert(point_q.size(), project_pixel(cmd));
            end
            if (!(start && busy))
            begin
                if (gap > 0)
                begin
                    gap <= gap - 1;
                    start <= 1'b0;
                end
                else if (pixel_q.size() > 0)
                begin
                    start <= 1'b1;
                    cmd <= pixel_q.pop_front();
                    gap <= ($urandom_range(0, 3) == 0) ? 0 :
                           (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 3));
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (point_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", result);
            end
            else
            begin
                mpgp_pkg::point_t e;
                e = point_q.pop_front();
                if (e !== result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", e, result);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || wr_en)
            wdog <= 0;
        else if (wdog >= WDOG_MAX)
        begin
            $display("mask_pixel_ground_projection test failed");
            $finish;
        end
        else
            wdog <= wdog + 1;
    end

    task automatic write_reg(logic [mpgp_pkg::REG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            mpgp_pkg::REG_FOCAL_X:       cam_fx = val[15:0];
            mpgp_pkg::REG_FOCAL_Y:       cam_fy = val[15:0];
            mpgp_pkg::REG_IMAGE_WIDTH:   img_w = val[12:0];
            mpgp_pkg::REG_IMAGE_HEIGHT:  img_h = val[12:0];
            mpgp_pkg::REG_SHIFT_X:       tr_x = val[31:0];
            mpgp_pkg::REG_SHIFT_Y:       tr_y = val[31:0];
            mpgp_pkg::REG_SHIFT_Z:       tr_z = val[31:0];
            mpgp_pkg::REG_ROTATION_QUAT: quat = val;
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain();
        wait (pixel_q.size() == 0 && !start && point_q.size() == 0);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_focal(int mode);
        case (mode)
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(200, 2000));
        endcase
    endfunction

    function automatic logic [15:0] pick_q(int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            default: return 16'($signed(16'($urandom_range(0, 32768))) - 16'sd16384);
        endcase
    endfunction

    function automatic logic [31:0] pick_shift(int mode, bit height);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom);
            default: return height ? 32'($urandom_range(6554, 655360)) :
                                     32'($urandom_range(0, 1310720)) - 32'd655360;
        endcase
    endfunction

    task automatic configure(int ph);
        int m;
        m = (ph == 1) ? 0 : (ph == 2) ? 1 : (ph == 3) ? 2 : 3;
        write_reg(mpgp_pkg::REG_FOCAL_X, 64'(pick_focal(m)));
        write_reg(mpgp_pkg::REG_FOCAL_Y, 64'(pick_focal(ph == 2 ? 0 : m)));
        write_reg(mpgp_pkg::REG_IMAGE_WIDTH, (m == 1) ? 64'h1FFF : (m == 0) ? 64'd1 :
                  64'($urandom_range(1, 4096)));
        write_reg(mpgp_pkg::REG_IMAGE_HEIGHT, (m == 1) ? 64'd1 : (m == 0) ? 64'h1FFF :
                  64'($urandom_range(1, 4096)));
        write_reg(mpgp_pkg::REG_SHIFT_X, 64'(pick_shift(m, 1'b0)));
        write_reg(mpgp_pkg::REG_SHIFT_Y, 64'(pick_shift(m == 0 ? 1 : m, 1'b0)));
        write_reg(mpgp_pkg::REG_SHIFT_Z, 64'(pick_shift(m, 1'b1)));
        write_reg(mpgp_pkg::REG_ROTATION_QUAT,
                  {pick_q(m), pick_q(m), pick_q(m == 0 ? 1 : m), pick_q(m)});
    endtask

    function automatic mpgp_pkg::pixel_t make_pixel(logic [11:0] r, logic [11:0] c,
                                                    logic [7:0] v, bit e);
        mpgp_pkg::pixel_t p;
        p.row = r;
        p.col = c;
        p.mask_value = v;
        p.end_of_frame = e;
        return p;
    endfunction

    function automatic mpgp_pkg::pixel_t random_pixel();
        mpgp_pkg::pixel_t p;
        p.row = ($urandom_range(0, 15) == 0) ? 12'd0 : 12'($urandom);
        p.col = 12'($urandom);
        p.mask_value = ($urandom_range(0, 9) < 7) ? mpgp_pkg::GROUND_VALUE : 8'($urandom);
        p.end_of_frame = ($urandom_range(0, 9) == 0);
        return p;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset set-up: corners and special pixels
        add_pixel(make_pixel(12'd0, 12'd320, mpgp_pkg::GROUND_VALUE, 1'b0));
        add_pixel(make_pixel(12'd0, 12'd0, 8'd0, 1'b1));
        add_pixel(make_pixel(12'd100, 12'd5, 8'd254, 1'b0));
        add_pixel(make_pixel(12'd240, 12'd320, mpgp_pkg::GROUND_VALUE, 1'b1));
        add_pixel(make_pixel(12'hFFF, 12'hFFF, mpgp_pkg::GROUND_VALUE, 1'b0));
        add_pixel(make_pixel(12'd1, 12'd0, mpgp_pkg::GROUND_VALUE, 1'b0));
        add_pixel(make_pixel(12'd1, 12'hFFF, mpgp_pkg::GROUND_VALUE, 1'b0));
        add_pixel(make_pixel(12'd480, 12'd640, mpgp_pkg::GROUND_VALUE, 1'b0));
        add_pixel(make_pixel(12'hFFF, 12'd0, 8'd0, 1'b0));
        add_pixel(make_pixel(12'd0, 12'hFFF, 8'd127, 1'b1));
        add_pixel(make_pixel(12'd0, 12'd7, mpgp_pkg::GROUND_VALUE, 1'b1));
        add_pixel(make_pixel(12'd800, 12'd10, 8'd128, 1'b0));
        for (int i = 0; i < 200; i++)
            add_pixel(random_pixel());
        drain();

        for (int ph = 1; ph <= 8; ph++)
        begin
            configure(ph);
            add_pixel(make_pixel(12'd0, 12'd0, mpgp_pkg::GROUND_VALUE, 1'b0));
            add_pixel(make_pixel(12'hFFF, 12'hFFF, mpgp_pkg::GROUND_VALUE, 1'b1));
            add_pixel(make_pixel(12'd1, 12'd1, mpgp_pkg::GROUND_VALUE, 1'b0));
            for (int i = 0; i < 200; i++)
                add_pixel(random_pixel());
            drain();
        end

        if (mismatches == 0)
            $display("mask_pixel_ground_projection test passed");
        else
            $display("mask_pixel_ground_projection test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/mpgp_pkg.sv
rtl/mpgp_div.sv
rtl/mpgp_rot.sv
rtl/mask_pixel_ground_projection.sv
tb/tb.sv
